@@ rtl/median_filter_3x3_assert.svh @@
// assertion helpers included by median_filter_3x3
`ifndef MEDIAN_FILTER_3X3_ASSERT_SVH
`define MEDIAN_FILTER_3X3_ASSERT_SVH

`ifndef SYNTHESIS

// checked property, switched off while reset is asserted
`define MF3_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property that also holds during reset
`define MF3_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MF3_ASSERT(name, clk, rst_n, prop, msg)
`define MF3_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

@@ rtl/mf3_pkg.sv @@
package mf3_pkg;

  // register reset values and smallest usable frame size
  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;
  localparam int unsigned MIN_SIZE     = 3;

  // register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [11:0] image_width;
    logic [15:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] median_value;
    logic       row_end;
    logic       last_of_frame;
  } out_item_t;

endpackage

@@ rtl/mf3_ram.sv @@
module mf3_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]               wdata_i,
  input  logic                           re_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]               rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/mf3_cfg.sv @@
module mf3_cfg
  import mf3_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [11:0] width_q;
  logic [15:0] height_q;
  logic        wr_en;
  reg_idx_e    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[2]);

  // register writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_IMAGE_WIDTH:  width_q  <= pwdata[11:0];
        REG_IMAGE_HEIGHT: height_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_IMAGE_WIDTH:  prdata = {20'b0, width_q};
      REG_IMAGE_HEIGHT: prdata = {16'b0, height_q};
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.image_width  = width_q;
  assign cfg_o.image_height = height_q;

endmodule

@@ rtl/mf3_median.sv @@
module mf3_median (
  input  logic [8:0][7:0] win_i,
  output logic [7:0]      median_o
);

  // returns {smaller, larger}
  function automatic logic [15:0] sort2(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? {b, a} : {a, b};
  endfunction

  logic [7:0] p [9];

  // nineteen compare-exchange median network, result lands in p[4]
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      p[i] = win_i[i];
    end
    {p[1], p[2]} = sort2(p[1], p[2]);
    {p[4], p[5]} = sort2(p[4], p[5]);
    {p[7], p[8]} = sort2(p[7], p[8]);
    {p[0], p[1]} = sort2(p[0], p[1]);
    {p[3], p[4]} = sort2(p[3], p[4]);
    {p[6], p[7]} = sort2(p[6], p[7]);
    {p[1], p[2]} = sort2(p[1], p[2]);
    {p[4], p[5]} = sort2(p[4], p[5]);
    {p[7], p[8]} = sort2(p[7], p[8]);
    {p[0], p[3]} = sort2(p[0], p[3]);
    {p[5], p[8]} = sort2(p[5], p[8]);
    {p[4], p[7]} = sort2(p[4], p[7]);
    {p[3], p[6]} = sort2(p[3], p[6]);
    {p[1], p[4]} = sort2(p[1], p[4]);
    {p[2], p[5]} = sort2(p[2], p[5]);
    {p[4], p[7]} = sort2(p[4], p[7]);
    {p[2], p[4]} = sort2(p[2], p[4]);
    {p[4], p[6]} = sort2(p[4], p[6]);
    {p[2], p[4]} = sort2(p[2], p[4]);
  end

  assign median_o = p[4];

endmodule

@@ rtl/median_filter_3x3.sv @@
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+------------------------------
// in       | input     | in_valid_i/in_ready_o  | in_data_i  (pixel, frame_start)
// out      | output    | out_valid_o/out_ready_i| out_data_o (median, row_end, last)
// cfg      | input     | psel/penable/pwrite    | paddr, pwdata, prdata
//
// one pixel per cycle sustained while results are taken at the output; each pixel
// enters the median stage with its line-store read, its result then the output register
// reset clears counters, window and valids; line stores need no clearing
// a stalled result holds in the output register; the next pixel still enters
// while the median stage is free to move on
module median_filter_3x3
  import mf3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "median_filter_3x3_assert.svh"

  localparam int unsigned AW = $clog2(MAX_WIDTH > 1 ? MAX_WIDTH : 2);
  localparam int unsigned WW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;

  cfg_t cfg;

  // frame position
  logic [AW-1:0] col_q, col_d;
  logic [15:0]   row_q, row_d;
  logic [WW-1:0] w_ext, w_use, col_cur, col_inc;
  logic [15:0]   h_use;
  logic [16:0]   row_cur, row_inc;
  logic [AW-1:0] col_a;
  logic [15:0]   row_a;
  logic          res_d, row_end_d, last_d;

  // median stage
  logic          s1_valid_q;
  logic [7:0]    s1_pix_q;
  logic [AW-1:0] s1_col_q;
  logic          s1_res_q, s1_row_end_q, s1_last_q;
  logic          byp_q;
  logic [15:0]   byp_data_q;
  logic [15:0]   ram_rdata, lines;
  logic [7:0]    top1, mid1;
  logic [7:0]    win_q [6];
  logic [7:0]    median;
  logic          adv1, acc, load_out;

  // output register
  logic          out_valid_q;
  out_item_t     out_data_q;

  mf3_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // clamp frame size, place the incoming pixel, step the counters
  always_comb begin
    w_ext = WW'(cfg.image_width);
    if (w_ext < WW'(MIN_SIZE)) begin
      w_use = WW'(MIN_SIZE);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_use = WW'(MAX_WIDTH);
    end else begin
      w_use = w_ext;
    end
    h_use = (cfg.image_height < 16'(MIN_SIZE)) ? 16'(MIN_SIZE) : cfg.image_height;

    col_cur = in_data_i.frame_start ? '0 : WW'(col_q);
    row_cur = in_data_i.frame_start ? '0 : {1'b0, row_q};
    if (col_cur >= w_use) begin
      col_cur = '0;
      row_cur = row_cur + 17'd1;
    end
    if (row_cur >= {1'b0, h_use}) begin
      row_cur = '0;
    end
    col_a = col_cur[AW-1:0];
    row_a = row_cur[15:0];

    res_d     = (row_a >= 16'd2) && (col_cur >= WW'(2));
    row_end_d = (col_cur == w_use - WW'(1));
    last_d    = row_end_d && (row_a == h_use - 16'd1);

    col_inc = col_cur + WW'(1);
    row_inc = {1'b0, row_a} + 17'd1;
    if (col_inc >= w_use) begin
      col_d = '0;
      row_d = (row_inc >= {1'b0, h_use}) ? 16'd0 : row_inc[15:0];
    end else begin
      col_d = col_inc[AW-1:0];
      row_d = row_a;
    end
  end

  // handshake
  assign adv1       = s1_valid_q && (!s1_res_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv1;
  assign acc        = in_valid_i && in_ready_o;
  assign load_out   = adv1 && s1_res_q;

  // both line stores in one word: {two rows above, one row above}
  mf3_ram #(
    .WIDTH (16),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (adv1),
    .waddr_i (s1_col_q),
    .wdata_i ({mid1, s1_pix_q}),
    .re_i    (acc),
    .raddr_i (col_a),
    .rdata_o (ram_rdata)
  );

  // forward the word written in the same cycle it was read
  assign lines = byp_q ? byp_data_q : ram_rdata;
  assign top1  = lines[15:8];
  assign mid1  = lines[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      if (acc) begin
        col_q <= col_d;
        row_q <= row_d;
        byp_q <= adv1 && (s1_col_q == col_a);
      end
      if (acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv1) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // median stage payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_pix_q     <= in_data_i.pixel;
      s1_col_q     <= col_a;
      s1_res_q     <= res_d;
      s1_row_end_q <= row_end_d;
      s1_last_q    <= last_d;
      byp_data_q   <= {mid1, s1_pix_q};
    end
  end

  // window shifts by one column per pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (adv1) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top1;
      win_q[4] <= mid1;
      win_q[5] <= s1_pix_q;
    end
  end

  mf3_median u_median (
    .win_i    ({s1_pix_q, mid1, top1, win_q[5], win_q[4], win_q[3],
                win_q[2], win_q[1], win_q[0]}),
    .median_o (median)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q.median_value  <= median;
      out_data_q.row_end       <= s1_row_end_q;
      out_data_q.last_of_frame <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `MF3_ASSERT(a_ready_only_blocked_by_stage, clk_i, rst_ni,
    !in_ready_o |-> s1_valid_q, "input stalled with empty median stage")
  `MF3_ASSERT(a_frame_start_col_zero, clk_i, rst_ni,
    (acc && in_data_i.frame_start) |=> (s1_col_q == '0), "frame start not at column zero")
  `MF3_ASSERT(a_col_in_range, clk_i, rst_ni,
    (WW'(col_q) < WW'(MAX_WIDTH)), "column counter beyond line store")
  `MF3_ASSERT(a_last_implies_row_end, clk_i, rst_ni,
    out_valid_o |-> (!out_data_o.last_of_frame || out_data_o.row_end), "last without row end")
  `MF3_ASSERT(a_result_from_stage, clk_i, rst_ni,
    $rose(out_valid_o) |-> $past(load_out), "result appeared without a median item")

endmodule
